### rtl/at_response_line_parser_defines.svh
// Assertion macros used by the top module of the response line parser.
`ifndef AT_RESPONSE_LINE_PARSER_DEFINES_SVH
`define AT_RESPONSE_LINE_PARSER_DEFINES_SVH

// Checks that a property holds on every clock edge outside reset.
`define ARLP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition never occurs outside reset.
`define ARLP_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

### rtl/arlp_pkg.sv
package arlp_pkg;

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_CMD     = 2'd1,
		OP_TIMEOUT = 2'd2,
		OP_RSVD    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_SKIP = 3'd1,
		PH_ZERO = 3'd2,
		PH_X    = 3'd3,
		PH_DIG  = 3'd4,
		PH_DONE = 3'd5
	} hex_phase_t;

	typedef enum logic [2:0] {
		ERR_NONE         = 3'd0,
		ERR_HTTP_CONNECT = 3'd1,
		ERR_HTTP_STATUS  = 3'd2,
		ERR_HTTP_OTHER   = 3'd3,
		ERR_GENERIC      = 3'd4
	} err_class_t;

	localparam logic [3:0] PFX_LEN = 4'd9;
	localparam logic [3:0] PFX_BAD = 4'd15;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam logic [7:0] LEN_OK    = 8'd2;
	localparam logic [7:0] LEN_ERROR = 8'd5;
	localparam logic [7:0] LEN_FAIL  = 8'd4;

	localparam logic [15:0] CODE_GROUP_MASK = 16'hF000;
	localparam logic [15:0] CODE_HTTP_GROUP = 16'h7000;
	localparam logic [15:0] CODE_HTTP_CONN  = 16'h7000;
	localparam logic [15:0] CODE_4XX_LO     = 16'h7190;
	localparam logic [15:0] CODE_4XX_HI     = 16'h719F;
	localparam logic [15:0] CODE_416_LO     = 16'h71A0;
	localparam logic [15:0] CODE_416_HI     = 16'h71A1;
	localparam logic [15:0] CODE_5XX_LO     = 16'h71F4;
	localparam logic [15:0] CODE_5XX_HI     = 16'h71F9;
	localparam logic [9:0]  STATUS_400      = 10'd400;
	localparam logic [9:0]  STATUS_416      = 10'd416;
	localparam logic [9:0]  STATUS_500      = 10'd500;

	typedef struct packed {
		logic         done;
		logic         ok;
		logic         waiting;
		err_class_t   cls;
		logic [31:0]  code;
		logic [9:0]   status;
	} result_t;

endpackage

### rtl/at_response_line_parser.sv
// Parses modem receive bytes and command/timeout marks, one beat per clock while the
// result side keeps up. Each input beat is captured in an input register, processed in
// a single pass against the line state and written to a result register, which then
// drives the outputs; the result register lets the next beat be accepted while a result
// still waits.
module at_response_line_parser #(
	parameter int unsigned LINE_CAPACITY = 192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        response_done,
	output logic        response_ok,
	output logic        still_waiting,
	output logic [2:0]  err_class,
	output logic [31:0] err_code,
	output logic [9:0]  http_status
);

	`include "at_response_line_parser_defines.svh"

	logic              valid_s1;
	arlp_pkg::op_t     op_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	logic              out_valid_q;
	arlp_pkg::result_t res;
	arlp_pkg::result_t res_s2;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= arlp_pkg::op_t'(op);
			byte_s1 <= in_byte;
		end
	end

	arlp_line_tracker #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.op      (op_s1),
		.in_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign response_done = res_s2.done;
	assign response_ok = res_s2.ok;
	assign still_waiting = res_s2.waiting;
	assign err_class = 3'(res_s2.cls);
	assign err_code = res_s2.code;
	assign http_status = res_s2.status;

	`ARLP_ASSERT(a_ok_implies_done, clk, arst_n,
		out_valid_q && res_s2.ok |-> res_s2.done, "ok without done")
	`ARLP_NEVER(a_done_still_waiting, clk, arst_n,
		out_valid_q && res_s2.done && res_s2.waiting, "wait kept after done")
	`ARLP_ASSERT(a_status_class, clk, arst_n,
		out_valid_q && res_s2.status != 10'd0 |-> res_s2.cls == arlp_pkg::ERR_HTTP_STATUS,
		"status outside status class")
	`ARLP_ASSERT(a_code_class, clk, arst_n,
		out_valid_q && res_s2.cls == arlp_pkg::ERR_NONE |-> res_s2.code == 32'd0,
		"code without class")

endmodule

### rtl/arlp_classify.sv
module arlp_classify (
	input  logic [31:0]         code,
	output arlp_pkg::err_class_t cls,
	output logic [9:0]          status
);

	logic [15:0] h;

	assign h = code[15:0];

	always_comb begin
		cls = arlp_pkg::ERR_NONE;
		status = 10'd0;
		priority if (code == 32'd0) begin
			cls = arlp_pkg::ERR_NONE;
		end else if ((h & arlp_pkg::CODE_GROUP_MASK) != arlp_pkg::CODE_HTTP_GROUP) begin
			cls = arlp_pkg::ERR_GENERIC;
		end else if (h == arlp_pkg::CODE_HTTP_CONN) begin
			cls = arlp_pkg::ERR_HTTP_CONNECT;
		end else if (h >= arlp_pkg::CODE_4XX_LO && h <= arlp_pkg::CODE_4XX_HI) begin
			cls = arlp_pkg::ERR_HTTP_STATUS;
			status = arlp_pkg::STATUS_400 + 10'(h - arlp_pkg::CODE_4XX_LO);
		end else if (h >= arlp_pkg::CODE_416_LO && h <= arlp_pkg::CODE_416_HI) begin
			cls = arlp_pkg::ERR_HTTP_STATUS;
			status = arlp_pkg::STATUS_416 + 10'(h - arlp_pkg::CODE_416_LO);
		end else if (h >= arlp_pkg::CODE_5XX_LO && h <= arlp_pkg::CODE_5XX_HI) begin
			cls = arlp_pkg::ERR_HTTP_STATUS;
			status = arlp_pkg::STATUS_500 + 10'(h - arlp_pkg::CODE_5XX_LO);
		end else begin
			cls = arlp_pkg::ERR_HTTP_OTHER;
		end
	end

endmodule

### rtl/arlp_line_tracker.sv
module arlp_line_tracker #(
	parameter int unsigned LINE_CAPACITY = 192
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  arlp_pkg::op_t     op,
	input  logic [7:0]        in_byte,
	output arlp_pkg::result_t res
);

	localparam logic [8:0] CAP = 9'(LINE_CAPACITY);

	typedef struct packed {
		logic       valid;
		logic [3:0] val;
	} hex_digit_t;

	function automatic logic kw_ok_keep(input logic [7:0] pos, input logic [7:0] c);
		logic [7:0] k;
		unique case (pos)
			8'd0:    k = "O";
			8'd1:    k = "K";
			default: k = 8'h00;
		endcase
		return (pos < arlp_pkg::LEN_OK) && (k == c);
	endfunction

	function automatic logic kw_error_keep(input logic [7:0] pos, input logic [7:0] c);
		logic [7:0] k;
		unique case (pos)
			8'd0:    k = "E";
			8'd1:    k = "R";
			8'd2:    k = "R";
			8'd3:    k = "O";
			8'd4:    k = "R";
			default: k = 8'h00;
		endcase
		return (pos < arlp_pkg::LEN_ERROR) && (k == c);
	endfunction

	function automatic logic kw_fail_keep(input logic [7:0] pos, input logic [7:0] c);
		logic [7:0] k;
		unique case (pos)
			8'd0:    k = "F";
			8'd1:    k = "A";
			8'd2:    k = "I";
			8'd3:    k = "L";
			default: k = 8'h00;
		endcase
		return (pos < arlp_pkg::LEN_FAIL) && (k == c);
	endfunction

	function automatic logic [7:0] pfx_char(input logic [3:0] idx);
		logic [7:0] k;
		unique case (idx)
			4'd0:    k = "E";
			4'd1:    k = "R";
			4'd2:    k = "R";
			4'd3:    k = " ";
			4'd4:    k = "C";
			4'd5:    k = "O";
			4'd6:    k = "D";
			4'd7:    k = "E";
			4'd8:    k = ":";
			default: k = 8'h00;
		endcase
		return k;
	endfunction

	function automatic hex_digit_t hex_value(input logic [7:0] c);
		hex_digit_t d;
		d.valid = 1'b1;
		d.val = 4'd0;
		priority if (c >= "0" && c <= "9") begin
			d.val = 4'(c - "0");
		end else if (c >= "a" && c <= "f") begin
			d.val = 4'(c - "a" + 8'd10);
		end else if (c >= "A" && c <= "F") begin
			d.val = 4'(c - "A" + 8'd10);
		end else begin
			d.valid = 1'b0;
		end
		return d;
	endfunction

	logic [7:0]             line_count_q, line_count_d;
	logic [2:0]             kw_flags_q, kw_flags_d;
	logic [3:0]             prefix_q, prefix_d;
	arlp_pkg::hex_phase_t   phase_q, phase_d;
	logic [31:0]            acc_q, acc_d;
	logic                   ovf_q, ovf_d;
	logic                   waiting_q, waiting_d;

	logic                   is_byte;
	logic                   append;
	logic                   hex_step;
	logic                   take;
	hex_digit_t             dig;
	logic                   is_space;
	logic [31:0]            line_code;
	arlp_pkg::err_class_t   line_cls;
	logic [9:0]             line_status;

	assign is_byte = (op == arlp_pkg::OP_BYTE) && (in_byte != arlp_pkg::CHAR_CR)
		&& (in_byte != arlp_pkg::CHAR_LF);
	assign append = is_byte && (({1'b0, line_count_q} + 9'd1) < CAP);
	assign hex_step = append && (prefix_q == arlp_pkg::PFX_LEN);
	assign dig = hex_value(in_byte);
	assign is_space = (in_byte == 8'h20) || (in_byte == 8'h09) || (in_byte == 8'h0B)
		|| (in_byte == 8'h0C);
	assign line_code = (prefix_q == arlp_pkg::PFX_LEN) ? acc_q : 32'd0;

	arlp_classify u_classify (
		.code   (line_code),
		.cls    (line_cls),
		.status (line_status)
	);

	// Next hex parsing phase.
	always_comb begin
		phase_d = phase_q;
		if (append && prefix_q < arlp_pkg::PFX_LEN && pfx_char(prefix_q) == in_byte
				&& prefix_q == arlp_pkg::PFX_LEN - 4'd1) begin
			phase_d = arlp_pkg::PH_SKIP;
		end else if (hex_step) begin
			unique case (phase_q)
				arlp_pkg::PH_SKIP: begin
					priority if (is_space) phase_d = arlp_pkg::PH_SKIP;
					else if (in_byte == "0") phase_d = arlp_pkg::PH_ZERO;
					else if (dig.valid) phase_d = arlp_pkg::PH_DIG;
					else phase_d = arlp_pkg::PH_DONE;
				end
				arlp_pkg::PH_ZERO: begin
					priority if (in_byte == "x" || in_byte == "X") phase_d = arlp_pkg::PH_X;
					else if (dig.valid) phase_d = arlp_pkg::PH_DIG;
					else phase_d = arlp_pkg::PH_DONE;
				end
				arlp_pkg::PH_X, arlp_pkg::PH_DIG: begin
					phase_d = dig.valid ? arlp_pkg::PH_DIG : arlp_pkg::PH_DONE;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// Whether the current byte is shifted into the accumulator.
	always_comb begin
		take = 1'b0;
		if (hex_step) begin
			unique case (phase_q)
				arlp_pkg::PH_SKIP: take = !is_space && in_byte != "0" && dig.valid;
				arlp_pkg::PH_ZERO: take = in_byte != "x" && in_byte != "X" && dig.valid;
				arlp_pkg::PH_X, arlp_pkg::PH_DIG: take = dig.valid;
				default: take = 1'b0;
			endcase
		end
	end

	always_comb begin
		line_count_d = line_count_q;
		kw_flags_d = kw_flags_q;
		prefix_d = prefix_q;
		acc_d = acc_q;
		ovf_d = ovf_q;
		waiting_d = waiting_q;
		res.done = 1'b0;
		res.ok = 1'b0;
		res.cls = arlp_pkg::ERR_NONE;
		res.code = 32'd0;
		res.status = 10'd0;

		unique case (op)
			arlp_pkg::OP_CMD: begin
				waiting_d = 1'b1;
			end
			arlp_pkg::OP_TIMEOUT: begin
				waiting_d = 1'b0;
			end
			arlp_pkg::OP_BYTE: begin
				if (in_byte == arlp_pkg::CHAR_LF && line_count_q != 8'd0) begin
					res.cls = line_cls;
					res.status = line_status;
					res.code = (line_cls != arlp_pkg::ERR_NONE) ? line_code : 32'd0;
					if (waiting_q) begin
						priority if (kw_flags_q[0] && line_count_q == arlp_pkg::LEN_OK) begin
							res.done = 1'b1;
							res.ok = 1'b1;
							waiting_d = 1'b0;
						end else if ((kw_flags_q[1] && line_count_q == arlp_pkg::LEN_ERROR)
								|| (kw_flags_q[2] && line_count_q == arlp_pkg::LEN_FAIL)) begin
							res.done = 1'b1;
							waiting_d = 1'b0;
						end else begin
							waiting_d = waiting_q;
						end
					end
				end else if (append) begin
					kw_flags_d[0] = kw_flags_q[0] && kw_ok_keep(line_count_q, in_byte);
					kw_flags_d[1] = kw_flags_q[1] && kw_error_keep(line_count_q, in_byte);
					kw_flags_d[2] = kw_flags_q[2] && kw_fail_keep(line_count_q, in_byte);
					if (prefix_q < arlp_pkg::PFX_LEN) begin
						prefix_d = (pfx_char(prefix_q) == in_byte) ? prefix_q + 4'd1
							: arlp_pkg::PFX_BAD;
					end
					if (take) begin
						if (ovf_q || acc_q > 32'h0FFF_FFFF) begin
							ovf_d = 1'b1;
							acc_d = 32'hFFFF_FFFF;
						end else begin
							acc_d = {acc_q[27:0], dig.val};
						end
					end
					line_count_d = line_count_q + 8'd1;
				end
			end
			default: begin
			end
		endcase

		// Command issue, line end, and overlong lines all start a fresh line.
		if (op == arlp_pkg::OP_CMD
				|| (op == arlp_pkg::OP_BYTE && in_byte == arlp_pkg::CHAR_LF
					&& line_count_q != 8'd0)
				|| (is_byte && !append)) begin
			line_count_d = 8'd0;
			kw_flags_d = 3'b111;
			prefix_d = 4'd0;
			acc_d = 32'd0;
			ovf_d = 1'b0;
		end

		res.waiting = waiting_d;
	end

	logic restart_phase;

	assign restart_phase = op == arlp_pkg::OP_CMD
		|| (op == arlp_pkg::OP_BYTE && in_byte == arlp_pkg::CHAR_LF && line_count_q != 8'd0)
		|| (is_byte && !append);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= 8'd0;
			kw_flags_q <= 3'b111;
			prefix_q <= 4'd0;
			phase_q <= arlp_pkg::PH_IDLE;
			acc_q <= 32'd0;
			ovf_q <= 1'b0;
			waiting_q <= 1'b0;
		end else if (step) begin
			line_count_q <= line_count_d;
			kw_flags_q <= kw_flags_d;
			prefix_q <= prefix_d;
			phase_q <= restart_phase ? arlp_pkg::PH_IDLE : phase_d;
			acc_q <= acc_d;
			ovf_q <= ovf_d;
			waiting_q <= waiting_d;
		end
	end

endmodule
